[hdl/first_fit_heap_allocator_assert.svh]
// Assertion macros used by the heap allocator walker.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define FFHA_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("heap allocator: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define FFHA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("heap allocator: next-cycle check failed");

`endif

[hdl/ffha_pkg.sv]
package ffha_pkg;

    localparam int unsigned HEAP_BYTES_DEF   = 65536;
    localparam int unsigned HEADER_BYTES_DEF = 16;
    localparam int unsigned HEAP_BYTES_RST   = 65536;

    localparam int unsigned REQ_W      = 17;
    localparam int unsigned NEED_W     = 18;
    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned HB_W       = 17;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BYTES = 2'd1;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_kind_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_FIT   = 2'd1,
        STAT_BAD_ADDR = 2'd2,
        STAT_NO_INIT  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_FREE_NEXT,
        ST_MERGE,
        ST_SPLIT,
        ST_RESP
    } walk_state_t;

    typedef struct packed {
        req_kind_t          req_type;
        logic [REQ_W-1:0]   req_bytes;
        logic [ADDR_W-1:0]  free_addr;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [ADDR_W-1:0]  block_addr;
    } res_t;

    // Byte offsets and sizes inside the region, able to hold the region size itself.
    function automatic int unsigned off_width(input int unsigned heap);
        return $clog2(heap + 1);
    endfunction

    // Block offsets are sums of headers and multiples of four: log2 of their granule.
    function automatic int unsigned gran_shift(input int unsigned hdr);
        int unsigned s;
        s = 0;
        if (hdr % 4 == 0) begin
            s = 2;
        end else if (hdr % 2 == 0) begin
            s = 1;
        end
        return s;
    endfunction

    function automatic int unsigned ram_depth(input int unsigned heap, input int unsigned hdr);
        return (heap + (1 << gran_shift(hdr)) - 1) >> gran_shift(hdr);
    endfunction

    function automatic int unsigned idx_width(input int unsigned heap, input int unsigned hdr);
        return $clog2(ram_depth(heap, hdr));
    endfunction

endpackage

[hdl/ffha_ram.sv]
module ffha_ram #(
    parameter int unsigned DW    = ffha_pkg::off_width(ffha_pkg::HEAP_BYTES_DEF) + 1,
    parameter int unsigned AW    = ffha_pkg::idx_width(ffha_pkg::HEAP_BYTES_DEF,
                                                       ffha_pkg::HEADER_BYTES_DEF),
    parameter int unsigned DEPTH = ffha_pkg::ram_depth(ffha_pkg::HEAP_BYTES_DEF,
                                                       ffha_pkg::HEADER_BYTES_DEF)
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/ffha_walker.sv]
`include "first_fit_heap_allocator_assert.svh"

module ffha_walker #(
    parameter  int unsigned HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
    parameter  int unsigned HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
    localparam int unsigned OFF_W        = ffha_pkg::off_width(HEAP_BYTES),
    localparam int unsigned AW           = ffha_pkg::idx_width(HEAP_BYTES, HEADER_BYTES),
    localparam int unsigned DW           = OFF_W + 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        init_req,
    output logic                        init_ack,
    input  logic [ffha_pkg::ADDR_W-1:0] heap_base,
    input  logic [OFF_W-1:0]            eff,
    input  logic                        empty,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  ffha_pkg::req_t              req,
    output logic                        res_valid,
    input  logic                        res_ready,
    output ffha_pkg::res_t              res,
    output logic                        mem_we,
    output logic [AW-1:0]               mem_waddr,
    output logic [DW-1:0]               mem_wdata,
    output logic                        mem_re,
    output logic [AW-1:0]               mem_raddr,
    input  logic [DW-1:0]               mem_rdata
);

    import ffha_pkg::*;

    localparam int unsigned GS        = gran_shift(HEADER_BYTES);
    localparam int unsigned CW        = ((OFF_W > NEED_W) ? OFF_W : NEED_W) + 1;
    localparam int unsigned MIN_SPLIT = HEADER_BYTES + 4;

    function automatic logic [AW-1:0] off_idx(input logic [OFF_W-1:0] off);
        return off[GS +: AW];
    endfunction

    walk_state_t         state_reg, state_next;
    req_kind_t           type_reg, type_next;
    logic [NEED_W-1:0]   need_reg, need_next;
    logic [ADDR_W-1:0]   target_reg, target_next;
    logic [OFF_W-1:0]    cur_off_reg, cur_off_next;
    logic                prev_valid_reg, prev_valid_next;
    logic                prev_used_reg, prev_used_next;
    logic [OFF_W-1:0]    prev_off_reg, prev_off_next;
    logic [OFF_W-1:0]    prev_size_reg, prev_size_next;
    logic [OFF_W-1:0]    merged_reg, merged_next;
    logic [OFF_W-1:0]    split_off_reg, split_off_next;
    logic [OFF_W-1:0]    split_size_reg, split_size_next;
    status_t             status_reg, status_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;

    logic                rd_used;
    logic [OFF_W-1:0]    rd_size;
    logic [OFF_W:0]      next_off;
    logic                last;
    logic [NEED_W-1:0]   need_sum;
    logic [NEED_W-1:0]   need_round;
    logic                fit;
    logic [CW-1:0]       rem;
    logic                split;
    logic [OFF_W-1:0]    split_off;
    logic [OFF_W-1:0]    split_size;
    logic [ADDR_W-1:0]   user_addr;
    logic                hit;
    logic                past;
    logic [OFF_W-1:0]    merged_plus;
    logic [OFF_W-1:0]    prev_merge;

    assign {rd_used, rd_size} = mem_rdata;

    // Header walk: the following block starts right after this one's payload.
    assign next_off = {1'b0, cur_off_reg} + (OFF_W+1)'(HEADER_BYTES) + {1'b0, rd_size};
    assign last     = next_off >= {1'b0, eff};

    assign need_sum   = NEED_W'(req.req_bytes) + NEED_W'(3);
    assign need_round = {need_sum[NEED_W-1:2], 2'b00};

    assign fit        = !rd_used && (CW'(rd_size) >= CW'(need_reg));
    assign rem        = CW'(rd_size) - CW'(need_reg);
    assign split      = rem >= CW'(MIN_SPLIT);
    assign split_off  = OFF_W'(CW'(cur_off_reg) + CW'(HEADER_BYTES) + CW'(need_reg));
    assign split_size = OFF_W'(rem - CW'(HEADER_BYTES));
    assign user_addr  = heap_base + ADDR_W'(cur_off_reg) + ADDR_W'(HEADER_BYTES);

    assign hit  = ADDR_W'(cur_off_reg) == target_reg;
    assign past = ADDR_W'(cur_off_reg) > target_reg;

    assign merged_plus = OFF_W'({1'b0, merged_reg} + (OFF_W+1)'(HEADER_BYTES)
                                + {1'b0, rd_size});
    assign prev_merge  = OFF_W'({1'b0, prev_size_reg} + (OFF_W+1)'(HEADER_BYTES)
                                + {1'b0, merged_reg});

    assign res = '{status: status_reg, block_addr: addr_reg};

    always_comb begin
        state_next      = state_reg;
        type_next       = type_reg;
        need_next       = need_reg;
        target_next     = target_reg;
        cur_off_next    = cur_off_reg;
        prev_valid_next = prev_valid_reg;
        prev_used_next  = prev_used_reg;
        prev_off_next   = prev_off_reg;
        prev_size_next  = prev_size_reg;
        merged_next     = merged_reg;
        split_off_next  = split_off_reg;
        split_size_next = split_size_reg;
        status_next     = status_reg;
        addr_next       = addr_reg;
        init_ack        = 1'b0;
        req_ready       = 1'b0;
        res_valid       = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = '0;

        case (state_reg)
            ST_IDLE: begin
                req_ready = !init_req;
                if (init_req) begin
                    // Lay down the single free block that spans the region.
                    init_ack = 1'b1;
                    if (!empty) begin
                        mem_we    = 1'b1;
                        mem_wdata = {1'b0, eff - OFF_W'(HEADER_BYTES)};
                    end
                end else if (req_valid) begin
                    type_next       = req.req_type;
                    need_next       = need_round;
                    target_next     = req.free_addr - heap_base - ADDR_W'(HEADER_BYTES);
                    addr_next       = '0;
                    cur_off_next    = '0;
                    prev_valid_next = 1'b0;
                    if (heap_base == '0) begin
                        status_next = STAT_NO_INIT;
                        state_next  = ST_RESP;
                    end else if (empty) begin
                        status_next = (req.req_type == REQ_FREE) ? STAT_BAD_ADDR : STAT_NO_FIT;
                        state_next  = ST_RESP;
                    end else begin
                        mem_re     = 1'b1;
                        state_next = ST_WALK;
                    end
                end
            end

            ST_WALK: begin
                if (type_reg == REQ_ALLOC) begin
                    if (fit) begin
                        mem_we          = 1'b1;
                        mem_waddr       = off_idx(cur_off_reg);
                        mem_wdata       = {1'b1, split ? OFF_W'(need_reg) : rd_size};
                        status_next     = STAT_OK;
                        addr_next       = user_addr;
                        split_off_next  = split_off;
                        split_size_next = split_size;
                        state_next      = split ? ST_SPLIT : ST_RESP;
                    end else if (last) begin
                        status_next = STAT_NO_FIT;
                        addr_next   = '0;
                        state_next  = ST_RESP;
                    end else begin
                        mem_re       = 1'b1;
                        mem_raddr    = off_idx(next_off[OFF_W-1:0]);
                        cur_off_next = next_off[OFF_W-1:0];
                    end
                end else begin
                    if (hit) begin
                        if (!rd_used) begin
                            status_next = STAT_BAD_ADDR;
                            state_next  = ST_RESP;
                        end else begin
                            merged_next = rd_size;
                            if (last) begin
                                state_next = ST_MERGE;
                            end else begin
                                // Hold cur_off on the hit block, fetch its successor.
                                mem_re     = 1'b1;
                                mem_raddr  = off_idx(next_off[OFF_W-1:0]);
                                state_next = ST_FREE_NEXT;
                            end
                        end
                    end else if (past || last) begin
                        status_next = STAT_BAD_ADDR;
                        state_next  = ST_RESP;
                    end else begin
                        prev_valid_next = 1'b1;
                        prev_used_next  = rd_used;
                        prev_off_next   = cur_off_reg;
                        prev_size_next  = rd_size;
                        mem_re          = 1'b1;
                        mem_raddr       = off_idx(next_off[OFF_W-1:0]);
                        cur_off_next    = next_off[OFF_W-1:0];
                    end
                end
            end

            ST_FREE_NEXT: begin
                if (!rd_used) begin
                    merged_next = merged_plus;
                end
                state_next = ST_MERGE;
            end

            ST_MERGE: begin
                mem_we = 1'b1;
                if (prev_valid_reg && !prev_used_reg) begin
                    mem_waddr = off_idx(prev_off_reg);
                    mem_wdata = {1'b0, prev_merge};
                end else begin
                    mem_waddr = off_idx(cur_off_reg);
                    mem_wdata = {1'b0, merged_reg};
                end
                status_next = STAT_OK;
                state_next  = ST_RESP;
            end

            ST_SPLIT: begin
                mem_we     = 1'b1;
                mem_waddr  = off_idx(split_off_reg);
                mem_wdata  = {1'b0, split_size_reg};
                state_next = ST_RESP;
            end

            ST_RESP: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            prev_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            prev_valid_reg <= prev_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        type_reg       <= type_next;
        need_reg       <= need_next;
        target_reg     <= target_next;
        cur_off_reg    <= cur_off_next;
        prev_used_reg  <= prev_used_next;
        prev_off_reg   <= prev_off_next;
        prev_size_reg  <= prev_size_next;
        merged_reg     <= merged_next;
        split_off_reg  <= split_off_next;
        split_size_reg <= split_size_next;
        status_reg     <= status_next;
        addr_reg       <= addr_next;
    end

    `FFHA_ASSERT_SAME(a_no_rw_clash, aclk, aresetn, mem_we && mem_re, mem_waddr != mem_raddr)
    `FFHA_ASSERT_SAME(a_walk_in_region, aclk, aresetn, state_reg == ST_WALK, cur_off_reg < eff)
    `FFHA_ASSERT_SAME(a_merge_frees, aclk, aresetn, state_reg == ST_MERGE, mem_we && !mem_wdata[DW-1])
    `FFHA_ASSERT_NEXT(a_no_init_answer, aclk, aresetn, req_valid && req_ready && (heap_base == '0), res_valid && (status_reg == STAT_NO_INIT))

endmodule

[hdl/first_fit_heap_allocator.sv]
// A request that fails at once (base zero or no block) goes straight to the response; an
// allocation visits headers in order until one fits (plus a split write), a free walks to
// its header, reads the successor unless it is last, and merges; a refused free skips merging.
// Throughput: one word at a time; the block RAM read port walks one header per cycle.
// Reset (aresetn low, synchronous): base 0, size 65536 clamped to HEAP_BYTES, then
// one cycle with s_ready low writes the single free block if the region holds one; same after a config write.
module first_fit_heap_allocator #(
    parameter int unsigned HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
    parameter int unsigned HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  ffha_pkg::req_t                  s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output ffha_pkg::res_t                  m_data,
    input  logic                            cfg_we,
    input  logic [ffha_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ffha_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    import ffha_pkg::*;

    localparam int unsigned OFF_W   = off_width(HEAP_BYTES);
    localparam int unsigned AW      = idx_width(HEAP_BYTES, HEADER_BYTES);
    localparam int unsigned DEPTH   = ram_depth(HEAP_BYTES, HEADER_BYTES);
    localparam int unsigned DW      = OFF_W + 1;
    localparam int unsigned EW      = (HB_W > OFF_W) ? HB_W : OFF_W;
    localparam int unsigned EFF_RST = (HEAP_BYTES_RST > HEAP_BYTES) ? HEAP_BYTES
                                                                    : HEAP_BYTES_RST;
    localparam int unsigned MIN_REGION = HEADER_BYTES + 4;

    // Configuration state: base address and the clamped region size.
    logic [ADDR_W-1:0] heap_base_reg, heap_base_next;
    logic [OFF_W-1:0]  eff_reg, eff_next;
    logic              empty_reg, empty_next;
    logic              init_pend_reg, init_pend_next;

    // Result register between the walker and the m_ side.
    logic              m_valid_reg, m_valid_next;
    res_t              m_data_reg, m_data_next;

    logic [EW-1:0]     hb_ext;
    logic [EW-1:0]     hb_clamp;
    logic              init_ack;
    logic              res_valid;
    logic              res_ready;
    res_t              res;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DW-1:0]     mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [DW-1:0]     mem_rdata;

    // Clamp an oversized region to what the block RAM covers.
    assign hb_ext   = EW'(cfg_wdata[HB_W-1:0]);
    assign hb_clamp = (hb_ext > EW'(HEAP_BYTES)) ? EW'(HEAP_BYTES) : hb_ext;

    always_comb begin
        heap_base_next = heap_base_reg;
        eff_next       = eff_reg;
        empty_next     = empty_reg;
        // Drop the pending init once the walker has laid down the first block.
        init_pend_next = init_pend_reg && !init_ack;
        if (cfg_we) begin
            case (cfg_index)
                CFG_HEAP_BASE: begin
                    heap_base_next = cfg_wdata[ADDR_W-1:0];
                    init_pend_next = 1'b1;
                end
                CFG_HEAP_BYTES: begin
                    eff_next       = hb_clamp[OFF_W-1:0];
                    empty_next     = hb_clamp < EW'(MIN_REGION);
                    init_pend_next = 1'b1;
                end
                default: begin
                    // Writes beyond the register list change nothing.
                end
            endcase
        end
    end

    // Take a finished result whenever the output register is free or drains now,
    // so the walker can accept the next word while this one waits.
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_data_next  = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_base_reg <= '0;
            eff_reg       <= OFF_W'(EFF_RST);
            empty_reg     <= EFF_RST < MIN_REGION;
            init_pend_reg <= 1'b1;
            m_valid_reg   <= 1'b0;
        end else begin
            heap_base_reg <= heap_base_next;
            eff_reg       <= eff_next;
            empty_reg     <= empty_next;
            init_pend_reg <= init_pend_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Block headers (payload size and used bit), one entry per offset granule.
    ffha_ram #(
        .DW    (DW),
        .AW    (AW),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Request sequencer: walks the header chain, splits and merges blocks.
    ffha_walker #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .init_req  (init_pend_reg),
        .init_ack  (init_ack),
        .heap_base (heap_base_reg),
        .eff       (eff_reg),
        .empty     (empty_reg),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .req       (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

endmodule

[sim/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ffha_pkg::*;

    localparam logic [31:0] HDR        = HEADER_BYTES_DEF;
    localparam logic [31:0] HEAP_MAX   = HEAP_BYTES_DEF;
    localparam int unsigned MAX_BLOCKS = HEAP_BYTES_DEF / HEADER_BYTES_DEF + 1;
    localparam int unsigned CYCLE_CAP  = 4_000_000;
    localparam int unsigned SHOW_MAX   = 10;

    // One heap block as the allocator sees it: region offset of the header,
    // payload bytes, and whether it is handed out.
    typedef struct {
        logic [31:0] off;
        logic [31:0] size;
        logic        used;
    } heap_blk_t;

    // A request together with the answer the heap map gives for it.
    typedef struct {
        req_t rq;
        res_t rs;
    } req_plan_t;

    logic    aclk      = 1'b0;
    logic    aresetn   = 1'b0;
    logic    s_valid   = 1'b0;
    logic    s_ready;
    req_t    s_data    = '0;
    logic    m_valid;
    logic    m_ready   = 1'b0;
    res_t    m_data;
    logic    cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Heap map mirror and its configuration.
    heap_blk_t   heap_map[$];
    logic [31:0] base_reg  = 32'd0;
    logic [16:0] bytes_reg = 17'd65536;

    // Addresses currently handed out, and the one most recently given back.
    logic [31:0] live_ptrs[$];
    logic [31:0] last_freed = 32'd0;

    req_plan_t   requests_pending[$];
    res_t        results_due[$];
    req_plan_t   cur_plan;
    bit          word_taken  = 1'b0;

    int unsigned s_idle_left = 0;
    int unsigned m_hold_left = 0;
    bit          s_calm      = 1'b0;
    bit          m_calm      = 1'b0;

    int unsigned fails       = 0;
    int unsigned result_cnt  = 0;
    int unsigned cycles      = 0;

    first_fit_heap_allocator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Heap map mirror
    // ------------------------------------------------------------------

    // Start over with one free block spanning the clamped region, or with
    // nothing at all when the region cannot hold a header plus one word.
    function automatic void rebuild_heap_map();
        logic [31:0] eff;
        heap_blk_t   blk;
        eff = (32'(bytes_reg) > HEAP_MAX) ? HEAP_MAX : 32'(bytes_reg);
        heap_map.delete();
        if (eff >= HDR + 32'd4) begin
            blk.off  = 32'd0;
            blk.size = eff - HDR;
            blk.used = 1'b0;
            heap_map.push_back(blk);
        end
    endfunction

    // Serve one request against the heap map and return the answer.
    function automatic res_t serve_request(input req_t rq);
        res_t        r;
        logic [31:0] need;
        logic [31:0] off;
        int unsigned i;
        heap_blk_t   nb;
        r.status     = STAT_OK;
        r.block_addr = 32'd0;
        if (base_reg == 32'd0) begin
            r.status = STAT_NO_INIT;
            return r;
        end
        if (rq.req_type == REQ_ALLOC) begin
            need = (32'(rq.req_bytes) + 32'd3) & ~32'd3;
            i = 0;
            while (i < heap_map.size() && (heap_map[i].used || heap_map[i].size < need)) begin
                i++;
            end
            if (i == heap_map.size()) begin
                r.status = STAT_NO_FIT;
                return r;
            end
            heap_map[i].used = 1'b1;
            // Split off the tail when it still holds a header and a word.
            if (heap_map[i].size - need >= HDR + 32'd4 && heap_map.size() < MAX_BLOCKS) begin
                nb.off  = heap_map[i].off + HDR + need;
                nb.size = heap_map[i].size - need - HDR;
                nb.used = 1'b0;
                heap_map[i].size = need;
                heap_map.insert(i + 1, nb);
            end
            r.block_addr = base_reg + heap_map[i].off + HDR;
        end else begin
            off = rq.free_addr - base_reg - HDR;
            i = 0;
            while (i < heap_map.size() && heap_map[i].off != off) begin
                i++;
            end
            if (i == heap_map.size() || !heap_map[i].used) begin
                r.status = STAT_BAD_ADDR;
                return r;
            end
            heap_map[i].used = 1'b0;
            // Coalesce with the successor first, then with the predecessor.
            if (i + 1 < heap_map.size() && !heap_map[i + 1].used) begin
                heap_map[i].size += HDR + heap_map[i + 1].size;
                heap_map.delete(i + 1);
            end
            if (i > 0 && !heap_map[i - 1].used) begin
                heap_map[i - 1].size += HDR + heap_map[i].size;
                heap_map.delete(i);
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(2, 1);
        end else if (r < 96) begin
            return $urandom_range(8, 3);
        end
        return $urandom_range(40, 15);
    endfunction

    function automatic logic [31:0] rand_base();
        logic [31:0] b;
        b = $urandom;
        if (b == 32'd0) begin
            b = 32'd1;
        end
        return b;
    endfunction

    // Queue one request; the field the request kind does not use gets noise.
    task automatic issue(input req_kind_t kind, input logic [16:0] nbytes,
                         input logic [31:0] addr);
        req_plan_t   p;
        int unsigned k;
        p.rq.req_type  = kind;
        p.rq.req_bytes = (kind == REQ_ALLOC) ? nbytes : 17'($urandom);
        p.rq.free_addr = (kind == REQ_FREE) ? addr : 32'($urandom);
        p.rs = serve_request(p.rq);
        requests_pending.push_back(p);
        if (p.rs.status == STAT_OK) begin
            if (kind == REQ_ALLOC) begin
                live_ptrs.push_back(p.rs.block_addr);
            end else begin
                last_freed = addr;
                for (k = 0; k < live_ptrs.size(); k++) begin
                    if (live_ptrs[k] == addr) begin
                        live_ptrs.delete(k);
                        break;
                    end
                end
            end
        end
    endtask

    // Give back every live block in random order.
    task automatic free_all();
        int unsigned k;
        while (live_ptrs.size() > 0) begin
            k = $urandom_range(live_ptrs.size() - 1);
            issue(REQ_FREE, 17'd0, live_ptrs[k]);
        end
    endtask

    // Block until no word waits to go in and no result is outstanding.
    task automatic wait_drained();
        while (requests_pending.size() != 0 || s_valid || results_due.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Write one register while the allocator is idle; either register
    // re-initializes the block table, so drop all live pointers too.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        wait_drained();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        if (idx == CFG_HEAP_BASE) begin
            base_reg = val;
        end else begin
            bytes_reg = val[16:0];
        end
        rebuild_heap_map();
        live_ptrs.delete();
    endtask

    task automatic setup(input logic [31:0] base, input logic [16:0] nbytes);
        write_reg(CFG_HEAP_BYTES, {15'($urandom), nbytes});
        write_reg(CFG_HEAP_BASE, base);
    endtask

    // Mostly well-formed alloc/free traffic with random sizes, a few bad
    // frees, and a final give-back of everything still held.
    task automatic mix(input int unsigned n, input int unsigned max_live,
                       input int unsigned size_cap);
        int unsigned r;
        int unsigned pick;
        logic [16:0] nb;
        logic [31:0] fa;
        repeat (n) begin
            r = $urandom_range(99);
            if (live_ptrs.size() == 0 || (r < 55 && live_ptrs.size() < max_live)) begin
                pick = $urandom_range(19);
                if (pick == 0) begin
                    nb = 17'($urandom);
                end else if (pick < 5) begin
                    nb = 17'($urandom_range(size_cap));
                end else begin
                    nb = 17'($urandom_range(48));
                end
                issue(REQ_ALLOC, nb, 32'd0);
            end else if (r < 93) begin
                issue(REQ_FREE, 17'd0, live_ptrs[$urandom_range(live_ptrs.size() - 1)]);
            end else begin
                pick = $urandom_range(3);
                if (pick == 0) begin
                    fa = $urandom;
                end else if (pick == 1) begin
                    fa = live_ptrs[$urandom_range(live_ptrs.size() - 1)]
                         + 32'(4 * $urandom_range(3, 1));
                end else if (pick == 2) begin
                    fa = last_freed;
                end else begin
                    fa = base_reg + HDR + 32'(4 * $urandom_range(64));
                end
                issue(REQ_FREE, 17'd0, fa);
            end
        end
        free_all();
    endtask

    // ------------------------------------------------------------------
    // Request driver: change inputs on the falling edge only
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (aresetn) begin
            // Hold the word until the rising edge has taken it.
            if (!s_valid || word_taken) begin
                word_taken = 1'b0;
                if ($urandom_range(63) == 0) begin
                    s_calm = !s_calm;
                end
                if (s_idle_left > 0) begin
                    s_idle_left--;
                    s_valid <= 1'b0;
                end else if (requests_pending.size() > 0) begin
                    cur_plan = requests_pending.pop_front();
                    s_data  <= cur_plan.rq;
                    s_valid <= 1'b1;
                    s_idle_left = s_calm ? 0 : pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result back-pressure: stall in random bursts, with calm stretches.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (m_hold_left > 0) begin
                m_hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(63) == 0) begin
                    m_calm = !m_calm;
                end
                if (!m_calm && $urandom_range(3) == 0) begin
                    m_hold_left = pick_gap() + 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample both handshakes on the rising edge
    // ------------------------------------------------------------------
    task automatic note_fail(input string msg);
        fails++;
        if (fails <= SHOW_MAX) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    always @(posedge aclk) begin
        res_t want;
        if (aresetn) begin
            // Record the expectation as soon as the request word is taken.
            if (s_valid && s_ready) begin
                results_due.push_back(cur_plan.rs);
                word_taken = 1'b1;
            end
            if (m_valid && m_ready) begin
                result_cnt++;
                if (results_due.size() == 0) begin
                    note_fail($sformatf("result %0d with nothing expected: status %0d addr %h",
                                        result_cnt, m_data.status, m_data.block_addr));
                end else begin
                    want = results_due.pop_front();
                    if (m_data.status !== want.status ||
                        m_data.block_addr !== want.block_addr) begin
                        note_fail($sformatf(
                            "result %0d: status exp %0d got %0d, block_addr exp %h got %h",
                            result_cnt, want.status, m_data.status,
                            want.block_addr, m_data.block_addr));
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycles++;
        if (cycles == CYCLE_CAP) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        logic [31:0] a;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;

        rebuild_heap_map();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Base is still zero after reset: nothing gets served.
        issue(REQ_ALLOC, 17'd4, 32'd0);
        issue(REQ_FREE, 17'd0, 32'h0000_0010);

        // Oversized region (clamped), upper data bits set as noise.
        write_reg(CFG_HEAP_BYTES, {15'h7fff, 17'h1ffff});
        write_reg(CFG_HEAP_BASE, 32'h8000_0000);
        issue(REQ_ALLOC, 17'd0, 32'd0);
        issue(REQ_ALLOC, 17'd1, 32'd0);
        issue(REQ_ALLOC, 17'h1ffff, 32'd0);
        issue(REQ_ALLOC, 17'd65484, 32'd0);
        a = live_ptrs[1];
        issue(REQ_FREE, 17'd0, a);
        issue(REQ_FREE, 17'd0, a);               // double free
        issue(REQ_FREE, 17'd0, 32'hffff_ffff);
        issue(REQ_FREE, 17'd0, 32'h8000_0000);   // points at the first header
        issue(REQ_FREE, 17'd0, live_ptrs[0]);    // merges with its successor
        issue(REQ_FREE, 17'd0, live_ptrs[0]);    // merges with its predecessor
        issue(REQ_ALLOC, 17'd65520, 32'd0);      // whole region in one block
        free_all();

        // Base near the top: user addresses wrap around zero.
        write_reg(CFG_HEAP_BASE, 32'hffff_fff8);
        issue(REQ_ALLOC, 17'd8, 32'd0);
        issue(REQ_ALLOC, 17'd8, 32'd0);
        issue(REQ_ALLOC, 17'd8, 32'd0);
        w0 = live_ptrs[0];
        w1 = live_ptrs[1];
        w2 = live_ptrs[2];
        issue(REQ_FREE, 17'd0, w0);
        issue(REQ_FREE, 17'd0, w2);
        issue(REQ_FREE, 17'd0, w1);              // merges on both sides

        // Tiny regions: too small for any block, then exactly one word.
        write_reg(CFG_HEAP_BYTES, 32'd19);
        issue(REQ_ALLOC, 17'd0, 32'd0);
        issue(REQ_FREE, 17'd0, base_reg + HDR);
        write_reg(CFG_HEAP_BYTES, 32'd20);
        issue(REQ_ALLOC, 17'd4, 32'd0);
        issue(REQ_ALLOC, 17'd0, 32'd0);
        issue(REQ_FREE, 17'd0, live_ptrs[0]);
        write_reg(CFG_HEAP_BYTES, 32'd0);
        issue(REQ_ALLOC, 17'd0, 32'd0);

        // Random traffic over a spread of regions.
        setup(rand_base(), 17'd65536);
        mix(280, 40, 4096);
        setup(rand_base(), 17'd4096);
        mix(220, 24, 512);
        setup(rand_base(), 17'd256);
        mix(180, 8, 96);
        setup(rand_base(), 17'($urandom_range(65536, 20)));
        mix(220, 32, 1024);
        setup(32'hffff_ffff, 17'd100000);
        mix(180, 32, 2048);
        setup(rand_base(), 17'($urandom_range(300, 20)));
        mix(130, 8, 64);
        write_reg(CFG_HEAP_BASE, 32'd0);
        mix(40, 8, 64);
        setup(rand_base(), 17'd65536);
        mix(230, 48, 256);

        wait_drained();
        repeat (40) @(posedge aclk);
        if (fails == 0 && results_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
